FILE: rtl/tss_pkg.sv
// shared constants for the triangle scanline span block
// no dependencies
package tss_pkg;

  localparam int unsigned CFG_W = 13;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-1:0] REG_VIS_WIDTH  = 3'd0;
  localparam logic [APB_ADDR_W-1:0] REG_VIS_HEIGHT = 3'd4;

  localparam logic [CFG_W-1:0] VIS_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] VIS_HEIGHT_RST = 13'd480;

endpackage

FILE: rtl/triangle_scanline_span.sv
// triangle scanline span: top level with register port and pipeline
// depends on tss_pkg, tss_setup, tss_div, tss_span
// start reaches done through the setup stages, the divider stages and the span output register, one word per cycle
// throughput one query each cycle; busy is always low
// the receiver cannot stall: done_o marks each result for one cycle
// reset clears valid bits and loads width 640, height 480
module triangle_scanline_span import tss_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  input  logic [COORD_BITS-1:0] vertex_a_x_i,
  input  logic [COORD_BITS-1:0] vertex_a_y_i,
  input  logic [COORD_BITS-1:0] vertex_b_x_i,
  input  logic [COORD_BITS-1:0] vertex_b_y_i,
  input  logic [COORD_BITS-1:0] vertex_c_x_i,
  input  logic [COORD_BITS-1:0] vertex_c_y_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [31:0]           fill_colour_i,
  output logic                  span_valid_o,
  output logic [COORD_BITS-1:0] span_left_o,
  output logic [COORD_BITS-1:0] span_right_o,
  output logic [COORD_BITS-1:0] span_row_o,
  output logic [31:0]           span_colour_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned N    = COORD_BITS;
  localparam int unsigned SB_W = 5 * N + 32 + 5;

  logic [CFG_W-1:0] width_q, height_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= VIS_WIDTH_RST;
      height_q <= VIS_HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr)
        REG_VIS_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_VIS_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_VIS_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_VIS_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:        prdata = '0;
    endcase
  end

  logic             su_valid, su_flat, su_hit, su_inr, su_neg_l, su_neg_s;
  logic [2*N-1:0]   su_num_l, su_num_s;
  logic [N-1:0]     su_dy_l, su_dy_s, su_row, su_fmin, su_fmax, su_xl, su_xs;
  logic [31:0]      su_col;

  tss_setup #(.N(N)) u_setup (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start && !busy),
    .ax_i            (vertex_a_x_i),
    .ay_i            (vertex_a_y_i),
    .bx_i            (vertex_b_x_i),
    .by_i            (vertex_b_y_i),
    .cx_i            (vertex_c_x_i),
    .cy_i            (vertex_c_y_i),
    .row_i           (row_i),
    .colour_i        (fill_colour_i),
    .row_limit_i     (height_q),
    .valid_o         (su_valid),
    .num_l_o         (su_num_l),
    .dy_l_o          (su_dy_l),
    .num_s_o         (su_num_s),
    .dy_s_o          (su_dy_s),
    .row_o           (su_row),
    .colour_o        (su_col),
    .flat_o          (su_flat),
    .hit_o           (su_hit),
    .inr_o           (su_inr),
    .fmin_o          (su_fmin),
    .fmax_o          (su_fmax),
    .xl_o            (su_xl),
    .xs_o            (su_xs),
    .neg_l_o         (su_neg_l),
    .neg_s_o         (su_neg_s)
  );

  logic [SB_W-1:0] sb_in, sb_out;
  logic            dv_valid;
  logic [N-1:0]    q_l, q_s;

  assign sb_in = {su_row, su_col, su_flat, su_hit, su_inr, su_fmin, su_fmax,
                  su_xl, su_xs, su_neg_l, su_neg_s};

  tss_div #(.N(N), .SB_W(SB_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (su_valid),
    .num_l_i (su_num_l),
    .dy_l_i  (su_dy_l),
    .num_s_i (su_num_s),
    .dy_s_i  (su_dy_s),
    .sb_i    (sb_in),
    .valid_o (dv_valid),
    .q_l_o   (q_l),
    .q_s_o   (q_s),
    .sb_o    (sb_out)
  );

  logic [N-1:0] dv_row, dv_fmin, dv_fmax, dv_xl, dv_xs;
  logic [31:0]  dv_col;
  logic         dv_flat, dv_hit, dv_inr, dv_neg_l, dv_neg_s;

  assign {dv_row, dv_col, dv_flat, dv_hit, dv_inr, dv_fmin, dv_fmax,
          dv_xl, dv_xs, dv_neg_l, dv_neg_s} = sb_out;

  tss_span #(.N(N)) u_span (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (dv_valid),
    .q_l_i          (q_l),
    .q_s_i          (q_s),
    .row_i          (dv_row),
    .colour_i       (dv_col),
    .flat_i         (dv_flat),
    .hit_i          (dv_hit),
    .inr_i          (dv_inr),
    .fmin_i         (dv_fmin),
    .fmax_i         (dv_fmax),
    .xl_i           (dv_xl),
    .xs_i           (dv_xs),
    .neg_l_i        (dv_neg_l),
    .neg_s_i        (dv_neg_s),
    .clip_width_i   (width_q),
    .done_o         (done_o),
    .span_valid_o   (span_valid_o),
    .span_left_o    (span_left_o),
    .span_right_o   (span_right_o),
    .span_row_o     (span_row_o),
    .span_colour_o  (span_colour_o)
  );

endmodule

FILE: rtl/tss_setup.sv
// front of the span pipeline: vertex sort, edge selection and products
// depends on tss_pkg
module tss_setup import tss_pkg::*; #(
  parameter int unsigned N = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [N-1:0]     ax_i,
  input  logic [N-1:0]     ay_i,
  input  logic [N-1:0]     bx_i,
  input  logic [N-1:0]     by_i,
  input  logic [N-1:0]     cx_i,
  input  logic [N-1:0]     cy_i,
  input  logic [N-1:0]     row_i,
  input  logic [31:0]      colour_i,
  input  logic [CFG_W-1:0] row_limit_i,
  output logic             valid_o,
  output logic [2*N-1:0]   num_l_o,
  output logic [N-1:0]     dy_l_o,
  output logic [2*N-1:0]   num_s_o,
  output logic [N-1:0]     dy_s_o,
  output logic [N-1:0]     row_o,
  output logic [31:0]      colour_o,
  output logic             flat_o,
  output logic             hit_o,
  output logic             inr_o,
  output logic [N-1:0]     fmin_o,
  output logic [N-1:0]     fmax_o,
  output logic [N-1:0]     xl_o,
  output logic [N-1:0]     xs_o,
  output logic             neg_l_o,
  output logic             neg_s_o
);

  localparam int unsigned CW = (N + 1 > CFG_W) ? N + 1 : CFG_W;

  // stage 1: sort by y
  logic [N-1:0] x0, y0, x1, y1, x2, y2, t0, t1;
  logic [N-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, row1_q;
  logic [31:0]  col1_q;
  logic         v1_q;

  always_comb begin
    x0 = ax_i; y0 = ay_i; x1 = bx_i; y1 = by_i; x2 = cx_i; y2 = cy_i;
    t0 = '0; t1 = '0;
    if (y0 > y1) begin
      t0 = x0; t1 = y0; x0 = x1; y0 = y1; x1 = t0; y1 = t1;
    end
    if (y1 > y2) begin
      t0 = x1; t1 = y1; x1 = x2; y1 = y2; x2 = t0; y2 = t1;
    end
    if (y0 > y1) begin
      t0 = x0; t1 = y0; x0 = x1; y0 = y1; x1 = t0; y1 = t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0; y0_q <= y0; x1_q <= x1; y1_q <= y1; x2_q <= x2; y2_q <= y2;
    row1_q <= row_i;
    col1_q <= colour_i;
  end

  // stage 2: case flags and edge differences
  logic         flat_d, hit_d, inr_d, neg_l_d, neg_s_d;
  logic [N-1:0] fmin_d, fmax_d, mag_l_d, dyy_l_d, dy_l_d, mag_s_d, dyy_s_d, dy_s_d, xs_d;
  logic [N-1:0] mag_l_q, dyy_l_q, dy_l_q, mag_s_q, dyy_s_q, dy_s_q, xs2_q, xl2_q;
  logic [N-1:0] fmin2_q, fmax2_q, row2_q;
  logic [31:0]  col2_q;
  logic         flat2_q, hit2_q, inr2_q, neg_l2_q, neg_s2_q, v2_q;

  always_comb begin
    flat_d = (y0_q == y2_q);
    hit_d  = (row1_q == y0_q);
    fmin_d = x0_q;
    fmax_d = x0_q;
    if (x1_q < fmin_d) fmin_d = x1_q;
    if (x1_q > fmax_d) fmax_d = x1_q;
    if (x2_q < fmin_d) fmin_d = x2_q;
    if (x2_q > fmax_d) fmax_d = x2_q;
    inr_d = !flat_d && (CW'(row1_q) < CW'(row_limit_i)) &&
            (row1_q >= y0_q) && (row1_q <= y2_q);
    neg_l_d = (x2_q < x0_q);
    mag_l_d = neg_l_d ? (x0_q - x2_q) : (x2_q - x0_q);
    dyy_l_d = row1_q - y0_q;
    dy_l_d  = y2_q - y0_q;
    if (row1_q <= y1_q) begin
      if (y1_q > y0_q) begin
        xs_d    = x0_q;
        neg_s_d = (x1_q < x0_q);
        mag_s_d = neg_s_d ? (x0_q - x1_q) : (x1_q - x0_q);
        dyy_s_d = row1_q - y0_q;
        dy_s_d  = y1_q - y0_q;
      end else begin
        xs_d    = x1_q;
        neg_s_d = 1'b0;
        mag_s_d = '0;
        dyy_s_d = '0;
        dy_s_d  = N'(1);
      end
    end else begin
      xs_d    = x1_q;
      neg_s_d = (x2_q < x1_q);
      mag_s_d = neg_s_d ? (x1_q - x2_q) : (x2_q - x1_q);
      dyy_s_d = row1_q - y1_q;
      dy_s_d  = y2_q - y1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flat2_q <= flat_d; hit2_q <= hit_d; inr2_q <= inr_d;
    fmin2_q <= fmin_d; fmax2_q <= fmax_d;
    neg_l2_q <= neg_l_d; mag_l_q <= mag_l_d; dyy_l_q <= dyy_l_d; dy_l_q <= dy_l_d;
    neg_s2_q <= neg_s_d; mag_s_q <= mag_s_d; dyy_s_q <= dyy_s_d; dy_s_q <= dy_s_d;
    xs2_q <= xs_d; xl2_q <= x0_q;
    row2_q <= row1_q; col2_q <= col1_q;
  end

  // stage 3: products
  logic [2*N-1:0] num_l_q, num_s_q;
  logic [N-1:0]   dy_l3_q, dy_s3_q, row3_q, fmin3_q, fmax3_q, xl3_q, xs3_q;
  logic [31:0]    col3_q;
  logic           flat3_q, hit3_q, inr3_q, neg_l3_q, neg_s3_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_l_q <= (2*N)'(mag_l_q) * (2*N)'(dyy_l_q);
    num_s_q <= (2*N)'(mag_s_q) * (2*N)'(dyy_s_q);
    dy_l3_q <= dy_l_q; dy_s3_q <= dy_s_q;
    row3_q <= row2_q; col3_q <= col2_q;
    flat3_q <= flat2_q; hit3_q <= hit2_q; inr3_q <= inr2_q;
    fmin3_q <= fmin2_q; fmax3_q <= fmax2_q;
    xl3_q <= xl2_q; xs3_q <= xs2_q; neg_l3_q <= neg_l2_q; neg_s3_q <= neg_s2_q;
  end

  assign valid_o  = v3_q;
  assign num_l_o  = num_l_q;
  assign dy_l_o   = dy_l3_q;
  assign num_s_o  = num_s_q;
  assign dy_s_o   = dy_s3_q;
  assign row_o    = row3_q;
  assign colour_o = col3_q;
  assign flat_o   = flat3_q;
  assign hit_o    = hit3_q;
  assign inr_o    = inr3_q;
  assign fmin_o   = fmin3_q;
  assign fmax_o   = fmax3_q;
  assign xl_o     = xl3_q;
  assign xs_o     = xs3_q;
  assign neg_l_o  = neg_l3_q;
  assign neg_s_o  = neg_s3_q;

endmodule

FILE: rtl/tss_div.sv
// pipelined restoring divider, two lanes, one quotient bit per stage
// quotient fits in N bits since the numerator is below dy * 2**N
module tss_div #(
  parameter int unsigned N    = 12,
  parameter int unsigned SB_W = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*N-1:0]  num_l_i,
  input  logic [N-1:0]    dy_l_i,
  input  logic [2*N-1:0]  num_s_i,
  input  logic [N-1:0]    dy_s_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [N-1:0]    q_l_o,
  output logic [N-1:0]    q_s_o,
  output logic [SB_W-1:0] sb_o
);

  logic [2*N-1:0]  rl [0:N];
  logic [2*N-1:0]  rs [0:N];
  logic [N-1:0]    dl [0:N];
  logic [N-1:0]    ds [0:N];
  logic [N-1:0]    ql [0:N];
  logic [N-1:0]    qs [0:N];
  logic [SB_W-1:0] sb [0:N];
  logic            v  [0:N];

  assign rl[0] = num_l_i;
  assign rs[0] = num_s_i;
  assign dl[0] = dy_l_i;
  assign ds[0] = dy_s_i;
  assign ql[0] = '0;
  assign qs[0] = '0;
  assign sb[0] = sb_i;
  assign v[0]  = valid_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [2*N-1:0] cmp_l, cmp_s;
    logic           bit_l, bit_s;

    assign cmp_l = (2*N)'(dl[s]) << (N - 1 - s);
    assign cmp_s = (2*N)'(ds[s]) << (N - 1 - s);
    assign bit_l = (rl[s] >= cmp_l);
    assign bit_s = (rs[s] >= cmp_s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rl[s+1] <= bit_l ? (rl[s] - cmp_l) : rl[s];
      rs[s+1] <= bit_s ? (rs[s] - cmp_s) : rs[s];
      ql[s+1] <= {ql[s][N-2:0], bit_l};
      qs[s+1] <= {qs[s][N-2:0], bit_s};
      dl[s+1] <= dl[s];
      ds[s+1] <= ds[s];
      sb[s+1] <= sb[s];
    end
  end

  assign valid_o = v[N];
  assign q_l_o   = ql[N];
  assign q_s_o   = qs[N];
  assign sb_o    = sb[N];

endmodule

FILE: rtl/tss_span.sv
// back of the span pipeline: edge x, ordering, right clip, output register
// depends on tss_pkg
module tss_span import tss_pkg::*; #(
  parameter int unsigned N = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [N-1:0]     q_l_i,
  input  logic [N-1:0]     q_s_i,
  input  logic [N-1:0]     row_i,
  input  logic [31:0]      colour_i,
  input  logic             flat_i,
  input  logic             hit_i,
  input  logic             inr_i,
  input  logic [N-1:0]     fmin_i,
  input  logic [N-1:0]     fmax_i,
  input  logic [N-1:0]     xl_i,
  input  logic [N-1:0]     xs_i,
  input  logic             neg_l_i,
  input  logic             neg_s_i,
  input  logic [CFG_W-1:0] clip_width_i,
  output logic             done_o,
  output logic             span_valid_o,
  output logic [N-1:0]     span_left_o,
  output logic [N-1:0]     span_right_o,
  output logic [N-1:0]     span_row_o,
  output logic [31:0]      span_colour_o
);

  localparam int unsigned CW = (N + 1 > CFG_W) ? N + 1 : CFG_W;

  logic [N:0]    ea, eb;
  logic [N-1:0]  xa, xb, left_d, right_d;
  logic [CW-1:0] sw, swm1;
  logic          valid_d;

  always_comb begin
    ea = {1'b0, xl_i} + (neg_l_i ? -{1'b0, q_l_i} : {1'b0, q_l_i});
    eb = {1'b0, xs_i} + (neg_s_i ? -{1'b0, q_s_i} : {1'b0, q_s_i});
    xa = (ea[N-1:0] > eb[N-1:0]) ? eb[N-1:0] : ea[N-1:0];
    xb = (ea[N-1:0] > eb[N-1:0]) ? ea[N-1:0] : eb[N-1:0];
    sw   = CW'(clip_width_i);
    swm1 = sw - CW'(1);
    left_d  = '0;
    right_d = '0;
    valid_d = 1'b0;
    if (flat_i) begin
      if (hit_i) begin
        valid_d = 1'b1;
        left_d  = fmin_i;
        right_d = fmax_i;
      end
    end else if (inr_i) begin
      if (CW'(xb) >= sw) begin
        valid_d = (sw != '0) && (CW'(xa) <= swm1);
        right_d = swm1[N-1:0];
      end else begin
        valid_d = 1'b1;
        right_d = xb;
      end
      left_d = xa;
    end
    if (!valid_d) begin
      left_d  = '0;
      right_d = '0;
    end
  end

  logic          done_q, sv_q;
  logic [N-1:0]  left_q, right_q, row_q;
  logic [31:0]   col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_q    <= valid_d;
    left_q  <= left_d;
    right_q <= right_d;
    row_q   <= row_i;
    col_q   <= colour_i;
  end

  assign done_o        = done_q;
  assign span_valid_o  = sv_q;
  assign span_left_o   = left_q;
  assign span_right_o  = right_q;
  assign span_row_o    = row_q;
  assign span_colour_o = col_q;

endmodule

FILE: sim/triangle_scanline_span_test.sv
// self-checking testbench for the triangle scanline span block
// depends on tss_pkg and triangle_scanline_span; drives queries and apb writes
module triangle_scanline_span_test;
  import tss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 12;

  typedef struct packed {
    logic          valid;
    logic [CB-1:0] left;
    logic [CB-1:0] right;
    logic [CB-1:0] row;
    logic [31:0]   colour;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o;
  logic [CB-1:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0, qrow = '0;
  logic [31:0] colour = '0;
  logic span_valid_o;
  logic [CB-1:0] span_left_o, span_right_o, span_row_o;
  logic [31:0] span_colour_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  span_t expected_spans[$];
  int errors = 0;
  bit gaps_on = 1'b1;
  longint unsigned cfg_width = 640, cfg_height = 480;

  triangle_scanline_span dut (
    .clk_i, .rst_ni, .start, .busy, .done_o,
    .vertex_a_x_i(ax), .vertex_a_y_i(ay), .vertex_b_x_i(bx), .vertex_b_y_i(by),
    .vertex_c_x_i(cx), .vertex_c_y_i(cy), .row_i(qrow), .fill_colour_i(colour),
    .span_valid_o, .span_left_o, .span_right_o, .span_row_o, .span_colour_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("triangle_scanline_span_test NOT OK");
    $finish;
  end

  function automatic longint edge_x(longint xs, longint ys, longint xe, longint ye,
                                    longint y);
    return xs + ((xe - xs) * (y - ys)) / (ye - ys);
  endfunction

  function automatic span_t predict_span(logic [CB-1:0] vx[3], logic [CB-1:0] vy[3],
                                         logic [CB-1:0] r, logic [31:0] c);
    longint px[3], py[3], t, y, xa, xb;
    bit valid, have;
    span_t s;
    xa = 0;
    xb = 0;
    valid = 0;
    for (int i = 0; i < 3; i++) begin
      px[i] = vx[i];
      py[i] = vy[i];
    end
    y = r;
    if (py[0] > py[1]) begin
      t = px[0]; px[0] = px[1]; px[1] = t; t = py[0]; py[0] = py[1]; py[1] = t;
    end
    if (py[1] > py[2]) begin
      t = px[1]; px[1] = px[2]; px[2] = t; t = py[1]; py[1] = py[2]; py[2] = t;
    end
    if (py[0] > py[1]) begin
      t = px[0]; px[0] = px[1]; px[1] = t; t = py[0]; py[0] = py[1]; py[1] = t;
    end
    if (py[0] == py[2]) begin
      if (y == py[0]) begin
        xa = px[0];
        xb = px[0];
        for (int i = 1; i < 3; i++) begin
          if (px[i] < xa) xa = px[i];
          if (px[i] > xb) xb = px[i];
        end
        valid = 1;
      end
    end else if (y < cfg_height && y >= py[0] && y <= py[2]) begin
      have = 1;
      if (y <= py[1]) begin
        xa = edge_x(px[0], py[0], px[2], py[2], y);
        xb = (py[1] > py[0]) ? edge_x(px[0], py[0], px[1], py[1], y) : px[1];
      end else if (py[2] > py[1]) begin
        xa = edge_x(px[0], py[0], px[2], py[2], y);
        xb = edge_x(px[1], py[1], px[2], py[2], y);
      end else begin
        have = 0;
      end
      if (have) begin
        if (xa > xb) begin
          t = xa; xa = xb; xb = t;
        end
        if (xa < 0) xa = 0;
        if (xb >= 0 && longint'(xb) >= longint'(cfg_width)) xb = cfg_width - 1;
        valid = (xa <= xb);
      end
    end
    if (!valid) begin
      xa = 0;
      xb = 0;
    end
    s.valid = valid;
    s.left = xa[CB-1:0];
    s.right = xb[CB-1:0];
    s.row = r;
    s.colour = c;
    return s;
  endfunction

  task automatic idle_burst();
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk_i);
    end
  endtask

  task automatic send_query(logic [CB-1:0] vx[3], logic [CB-1:0] vy[3], logic [CB-1:0] r,
                            logic [31:0] c);
    idle_burst();
    start <= 1'b1;
    {ax, bx, cx} <= {vx[0], vx[1], vx[2]};
    {ay, by, cy} <= {vy[0], vy[1], vy[2]};
    qrow <= r;
    colour <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_spans.push_back(predict_span(vx, vy, r, c));
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_spans.size() != 0) @(negedge clk_i);
    repeat (CB + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_VIS_WIDTH) cfg_width = data & 32'h1fff;
    else cfg_height = data & 32'h1fff;
    @(negedge clk_i);
  endtask

  task automatic set_screen(int w, int h);
    drain();
    write_reg(REG_VIS_WIDTH, w);
    write_reg(REG_VIS_HEIGHT, h);
  endtask

  function automatic logic [CB-1:0] rand_coord(int hi);
    return (hi >= 4095 && $urandom_range(7) == 0) ? CB'($urandom_range(4095, 4000))
                                                  : CB'($urandom_range(hi));
  endfunction

  // random triangle with a query row mostly inside its y range
  task automatic random_query(int hi);
    logic [CB-1:0] vx[3], vy[3], r;
    int lo_y, hi_y;
    for (int i = 0; i < 3; i++) begin
      vx[i] = rand_coord(hi);
      vy[i] = rand_coord(hi);
    end
    if ($urandom_range(9) == 0) vy[1] = vy[0];
    if ($urandom_range(9) == 0) vy[2] = vy[1];
    lo_y = vy[0] < vy[1] ? vy[0] : vy[1];
    lo_y = vy[2] < lo_y ? vy[2] : lo_y;
    hi_y = vy[0] > vy[1] ? vy[0] : vy[1];
    hi_y = vy[2] > hi_y ? vy[2] : hi_y;
    if ($urandom_range(7) == 0) r = CB'($urandom);
    else r = CB'($urandom_range(hi_y, lo_y));
    send_query(vx, vy, r, $urandom);
  endtask

  task automatic test_directed();
    send_query('{0, 0, 0}, '{0, 0, 0}, 0, 32'h0);
    send_query('{4095, 0, 100}, '{7, 7, 7}, 7, 32'hffff_ffff);
    send_query('{4095, 0, 100}, '{7, 7, 7}, 8, 32'h1234_5678);
    send_query('{10, 50, 30}, '{0, 0, 100}, 0, 32'ha5a5_a5a5);
    send_query('{10, 50, 30}, '{0, 0, 100}, 50, 32'h5a5a_5a5a);
    send_query('{0, 600, 0}, '{0, 100, 200}, 100, 32'h1);
    send_query('{0, 600, 0}, '{0, 100, 200}, 150, 32'h2);
    send_query('{100, 0, 700}, '{200, 0, 100}, 50, 32'h3);
    send_query('{100, 0, 700}, '{100, 100, 0}, 100, 32'h4);
    send_query('{4095, 0, 4095}, '{0, 4095, 4095}, 479, 32'h5);
    send_query('{4095, 0, 4095}, '{0, 4095, 4095}, 480, 32'h6);
    send_query('{4095, 0, 4095}, '{0, 4095, 4095}, 4095, 32'h7);
    send_query('{5, 9, 1}, '{300, 10, 20}, 2000, 32'h8);
    send_query('{200, 100, 300}, '{0, 50, 100}, 75, 32'h9);
  endtask

  task automatic test_extreme_screens();
    set_screen(0, 0);
    send_query('{1, 9, 5}, '{3, 3, 3}, 3, 32'hc0);
    send_query('{10, 50, 30}, '{0, 0, 100}, 20, 32'hc1);
    set_screen(8191, 8191);
    send_query('{4095, 0, 4095}, '{0, 4095, 4095}, 4095, 32'hc2);
    send_query('{0, 4095, 2000}, '{0, 10, 4095}, 4000, 32'hc3);
    set_screen(1, 1);
    send_query('{0, 50, 20}, '{0, 40, 80}, 0, 32'hc4);
    set_screen(4096, 4096);
    repeat (100) random_query(4095);
  endtask

  task automatic test_random_sweep();
    int w, h;
    for (int p = 0; p < 6; p++) begin
      w = $urandom_range(4096, 1);
      h = $urandom_range(4096, 1);
      set_screen(w, h);
      repeat (200) random_query(p[0] ? 4095 : 800);
    end
  endtask

  task automatic test_back_to_back();
    drain();
    gaps_on = 1'b0;
    repeat (300) random_query(4095);
  endtask

  always @(posedge clk_i) begin
    span_t want;
    span_t got;
    if (rst_ni && done_o) begin
      got = '{span_valid_o, span_left_o, span_right_o, span_row_o, span_colour_o};
      if (expected_spans.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %p", $time, got);
      end else begin
        want = expected_spans.pop_front();
        if (got.valid !== want.valid)
          $display("%0t: valid exp %0d got %0d", $time, want.valid, got.valid);
        if (got.left !== want.left)
          $display("%0t: left exp %0d got %0d", $time, want.left, got.left);
        if (got.right !== want.right)
          $display("%0t: right exp %0d got %0d", $time, want.right, got.right);
        if (got.row !== want.row)
          $display("%0t: row exp %0d got %0d", $time, want.row, got.row);
        if (got.colour !== want.colour)
          $display("%0t: colour exp %h got %h", $time, want.colour, got.colour);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_extreme_screens();
    test_random_sweep();
    test_back_to_back();
    drain();
    if (errors == 0) begin
      $display("triangle_scanline_span_test OK");
    end else begin
      $display("triangle_scanline_span_test NOT OK");
    end
    $finish;
  end

endmodule
